@@ rtl/mrv_pkg.sv @@
`timescale 1ns / 1ps

package mrv_pkg;

    localparam int MODE_COUNT         = 16;
    localparam int MODE_IDX_W         = $clog2(MODE_COUNT);
    localparam int COSINE_TABLE_DEPTH = 256;
    localparam int COS_IDX_W          = $clog2(COSINE_TABLE_DEPTH);

    // Shared multiplier geometry: 25 x 25 signed, 50-bit product.
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    // Wide product accumulator and the sample accumulator.
    localparam int T_W    = 66;
    localparam int ACC_W  = 48;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    localparam logic [4:0]  ACTIVE_MODES_RST   = 5'd8;
    localparam logic [16:0] STRIKE_SAMPLES_RST = 17'd48;
    localparam logic [16:0] NOISE_SAMPLES_RST  = 17'd480;
    localparam logic [23:0] NOISE_GAIN_RST     = 24'd0;
    localparam logic [23:0] NOISE_DECAY_RST    = 24'hFFFFFF;
    localparam logic [31:0] RNG_SEED_RST       = 32'd1;

    localparam logic [2:0] MODE_LAST_PH  = 3'd5;
    localparam logic [2:0] NOISE_LAST_PH = 3'd4;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_NOTE_ON = 2'd1,
        CMD_TICK    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_ACTIVE_MODES   = 3'd0,
        CFG_STRIKE_SAMPLES = 3'd1,
        CFG_NOISE_SAMPLES  = 3'd2,
        CFG_NOISE_GAIN     = 3'd3,
        CFG_NOISE_DECAY    = 3'd4,
        CFG_RNG_SEED       = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXC,
        ST_MODE,
        ST_NOISE,
        ST_DONE
    } state_t;

    typedef logic [22:0] cos_tab_t [COSINE_TABLE_DEPTH];

    // Quarter-wave cosine, Q1.22, from a Q30 Taylor series up to x^16.
    // Each term divides by (2n-1)*(2n), written out for n = 1 to 8.
    function automatic logic [22:0] cos_entry(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = 64'd1686629713 * longint'(k) / COSINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = 64'd1073741824;
        sum  = 64'sd1073741824;
        term = ((term * x2) >> 30) / 64'd2;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd12;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd30;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd56;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd90;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd132;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd182;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd240;
        sum  = sum + longint'(term);
        if (sum < 0)
            sum = 0;
        sum = (sum + 128) >>> 8;
        if (sum > (64'sd1 <<< 22))
            sum = 64'sd1 <<< 22;
        return sum[22:0];
    endfunction

    function automatic cos_tab_t build_cos_table();
        cos_tab_t t;
        for (int k = 0; k < COSINE_TABLE_DEPTH; k++)
        begin
            t[k] = cos_entry(k);
        end
        return t;
    endfunction

    localparam cos_tab_t COS_TABLE = build_cos_table();

    // Clamp a 48-bit signed value to the Q16.24 range.
    function automatic logic signed [39:0] sat40(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(40'sh7F_FFFF_FFFF);
        lo = -hi - ACC_W'(1);
        if (v > hi)
            return 40'sh7F_FFFF_FFFF;
        else if (v < lo)
            return 40'sh80_0000_0000;
        else
            return v[39:0];
    endfunction

endpackage

@@ rtl/mrv_in_if.sv @@
`timescale 1ns / 1ps

interface mrv_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  mode_index;
    logic signed [23:0] feedback_coeff;
    logic [22:0] pole_radius_sq;
    logic [22:0] mode_gain;

    modport source (output valid, cmd, mode_index, feedback_coeff, pole_radius_sq,
                    mode_gain, input ready);
    modport sink (input valid, cmd, mode_index, feedback_coeff, pole_radius_sq,
                  mode_gain, output ready);
endinterface

@@ rtl/mrv_out_if.sv @@
`timescale 1ns / 1ps

interface mrv_out_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink (input valid, sample_out, output ready);
endinterface

@@ rtl/mrv_cfg_if.sv @@
`timescale 1ns / 1ps

interface mrv_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [31:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/modal_resonator_voice.sv @@
`timescale 1ns / 1ps

// A tick beat visits N mode slots, N being the clamped active mode count, plus
// an envelope step while the strike envelope runs and a noise step while the
// noise burst runs; the single shared 25x25 multiplier is used five times per
// mode. One item is in flight at a time. Reset (rst_n, asynchronous, active low)
// clears all stores, envelopes and the output beat, restores the register
// defaults and the seed.
module modal_resonator_voice (
    input  logic       clk,
    input  logic       rst_n,
    mrv_in_if.sink     voice_in,
    mrv_out_if.source  voice_out,
    mrv_cfg_if.sink    cfg
);

    // Configuration registers.
    logic [4:0]  active_modes_reg;
    logic [16:0] strike_samples_reg;
    logic [16:0] noise_samples_reg;
    logic [23:0] noise_gain_reg;
    logic [23:0] noise_decay_reg;

    // Resonator bank; each store is read only at the current mode slot.
    logic signed [39:0] delay_one_reg [mrv_pkg::MODE_COUNT];
    logic signed [39:0] delay_two_reg [mrv_pkg::MODE_COUNT];
    logic signed [23:0] coeff_reg     [mrv_pkg::MODE_COUNT];
    logic [22:0]        radius_reg    [mrv_pkg::MODE_COUNT];
    logic [22:0]        gain_reg      [mrv_pkg::MODE_COUNT];

    // Envelope and noise state.
    logic [16:0] strike_left_reg;
    logic [16:0] noise_left_reg;
    logic [23:0] noise_level_reg;
    logic [31:0] lcg_reg;

    // Sequencer and datapath registers.
    mrv_pkg::state_t state_reg, state_next;
    logic [2:0]                          phase_reg;
    logic [mrv_pkg::MODE_IDX_W-1:0]      mode_reg;
    logic [22:0]                         exc_reg;
    logic signed [mrv_pkg::T_W-1:0]      t_reg;
    logic signed [mrv_pkg::ACC_W-1:0]    y_reg;
    logic signed [mrv_pkg::ACC_W-1:0]    acc_reg;
    logic                                out_valid_reg;
    logic signed [39:0]                  out_data_reg;

    logic                              in_beat;
    logic                              out_free;
    logic [mrv_pkg::MODE_IDX_W-1:0]    mode_last;
    logic [16:0]                       total;
    logic [16:0]                       elapsed;
    logic signed [39:0]                s1;
    logic signed [39:0]                s2;
    logic signed [31:0]                noise_r;
    logic signed [mrv_pkg::MUL_W-1:0]  op_a;
    logic signed [mrv_pkg::MUL_W-1:0]  op_b;
    logic signed [mrv_pkg::PROD_W-1:0] prod;
    logic signed [mrv_pkg::T_W-1:0]    prod_ext;
    logic signed [mrv_pkg::ACC_W-1:0]  y_sum;
    logic signed [39:0]                y_new;
    logic                              div_start;
    logic                              div_done;
    logic [mrv_pkg::COS_IDX_W-1:0]     div_quot;
    logic [31:0]                       lcg_next;

    assign in_beat  = voice_in.valid && voice_in.ready;
    assign out_free = !out_valid_reg || voice_out.ready;

    // Clamp of the active mode count, expressed as the last slot visited.
    always_comb
    begin
        if (active_modes_reg < 5'd2)
            mode_last = mrv_pkg::MODE_IDX_W'(1);
        else if (32'(active_modes_reg) > mrv_pkg::MODE_COUNT)
            mode_last = mrv_pkg::MODE_IDX_W'(mrv_pkg::MODE_COUNT - 1);
        else
            mode_last = mrv_pkg::MODE_IDX_W'(active_modes_reg - 5'd1);
    end

    // The envelope position. If the length register shrank mid-note, the
    // elapsed count is taken as zero.
    assign total   = (strike_samples_reg == 17'd0) ? 17'd1 : strike_samples_reg;
    assign elapsed = (total > strike_left_reg) ? 17'(total - strike_left_reg) : 17'd0;

    assign s1       = delay_one_reg[mode_reg];
    assign s2       = delay_two_reg[mode_reg];
    assign noise_r  = {~lcg_reg[31], lcg_reg[30:0]};
    assign prod_ext = mrv_pkg::T_W'(prod);
    assign lcg_next = 32'(lcg_reg * mrv_pkg::LCG_MUL + mrv_pkg::LCG_ADD);

    // The closing step of a mode: feedback minus damping plus drive. The
    // damping product sits in t_reg and the drive product has just landed.
    assign y_sum = y_reg - mrv_pkg::ACC_W'(t_reg >>> 22) + mrv_pkg::ACC_W'(prod >>> 20);
    assign y_new = mrv_pkg::sat40(y_sum);

    mrv_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    mrv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed),
        .divisor  (total),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrv_pkg::ST_IDLE:
            begin
                if (in_beat && voice_in.cmd == mrv_pkg::CMD_TICK)
                begin
                    if (strike_left_reg != 17'd0)
                        state_next = mrv_pkg::ST_DIV;
                    else
                        state_next = mrv_pkg::ST_MODE;
                end
            end
            mrv_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = mrv_pkg::ST_EXC;
            end
            mrv_pkg::ST_EXC:
            begin
                state_next = mrv_pkg::ST_MODE;
            end
            mrv_pkg::ST_MODE:
            begin
                if (phase_reg == mrv_pkg::MODE_LAST_PH && mode_reg == mode_last)
                begin
                    if (noise_left_reg != 17'd0)
                        state_next = mrv_pkg::ST_NOISE;
                    else
                        state_next = mrv_pkg::ST_DONE;
                end
            end
            mrv_pkg::ST_NOISE:
            begin
                if (phase_reg == mrv_pkg::NOISE_LAST_PH)
                    state_next = mrv_pkg::ST_DONE;
            end
            mrv_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = mrv_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mrv_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshakes, divider start and the operands
    // for the shared multiplier in each phase.
    always_comb
    begin
        voice_in.ready = (state_reg == mrv_pkg::ST_IDLE);
        div_start      = (state_reg == mrv_pkg::ST_IDLE) && in_beat
                         && voice_in.cmd == mrv_pkg::CMD_TICK
                         && strike_left_reg != 17'd0;
        op_a = '0;
        op_b = '0;
        case (state_reg)
            mrv_pkg::ST_MODE:
            begin
                case (phase_reg)
                    3'd0:
                    begin
                        op_a = mrv_pkg::MUL_W'(coeff_reg[mode_reg]);
                        op_b = {5'b0, s1[19:0]};
                    end
                    3'd1:
                    begin
                        op_a = mrv_pkg::MUL_W'(coeff_reg[mode_reg]);
                        op_b = {{5{s1[39]}}, s1[39:20]};
                    end
                    3'd2:
                    begin
                        op_a = {2'b0, radius_reg[mode_reg]};
                        op_b = {5'b0, s2[19:0]};
                    end
                    3'd3:
                    begin
                        op_a = {2'b0, radius_reg[mode_reg]};
                        op_b = {{5{s2[39]}}, s2[39:20]};
                    end
                    3'd4:
                    begin
                        op_a = {2'b0, exc_reg};
                        op_b = {2'b0, gain_reg[mode_reg]};
                    end
                    default:
                    begin
                        op_a = '0;
                        op_b = '0;
                    end
                endcase
            end
            mrv_pkg::ST_NOISE:
            begin
                case (phase_reg)
                    3'd1:
                    begin
                        op_a = {1'b0, noise_level_reg};
                        op_b = {9'b0, noise_r[15:0]};
                    end
                    3'd2:
                    begin
                        op_a = {1'b0, noise_level_reg};
                        op_b = {{9{noise_r[31]}}, noise_r[31:16]};
                    end
                    3'd3:
                    begin
                        op_a = {1'b0, noise_level_reg};
                        op_b = {1'b0, noise_decay_reg};
                    end
                    default:
                    begin
                        op_a = '0;
                        op_b = '0;
                    end
                endcase
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign cfg.ready        = 1'b1;
    assign voice_out.valid      = out_valid_reg;
    assign voice_out.sample_out = out_data_reg;

    // Control state, configuration, stores and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= mrv_pkg::ST_IDLE;
            phase_reg          <= '0;
            mode_reg           <= '0;
            active_modes_reg   <= mrv_pkg::ACTIVE_MODES_RST;
            strike_samples_reg <= mrv_pkg::STRIKE_SAMPLES_RST;
            noise_samples_reg  <= mrv_pkg::NOISE_SAMPLES_RST;
            noise_gain_reg     <= mrv_pkg::NOISE_GAIN_RST;
            noise_decay_reg    <= mrv_pkg::NOISE_DECAY_RST;
            lcg_reg            <= mrv_pkg::RNG_SEED_RST;
            strike_left_reg    <= '0;
            noise_left_reg     <= '0;
            noise_level_reg    <= '0;
            out_valid_reg      <= 1'b0;
            for (int i = 0; i < mrv_pkg::MODE_COUNT; i++)
            begin
                delay_one_reg[i] <= '0;
                delay_two_reg[i] <= '0;
                coeff_reg[i]     <= '0;
                radius_reg[i]    <= '0;
                gain_reg[i]      <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    mrv_pkg::CFG_ACTIVE_MODES:   active_modes_reg   <= cfg.wdata[4:0];
                    mrv_pkg::CFG_STRIKE_SAMPLES: strike_samples_reg <= cfg.wdata[16:0];
                    mrv_pkg::CFG_NOISE_SAMPLES:  noise_samples_reg  <= cfg.wdata[16:0];
                    mrv_pkg::CFG_NOISE_GAIN:     noise_gain_reg     <= cfg.wdata[23:0];
                    mrv_pkg::CFG_NOISE_DECAY:    noise_decay_reg    <= cfg.wdata[23:0];
                    mrv_pkg::CFG_RNG_SEED:       lcg_reg            <= cfg.wdata;
                    default:
                    begin
                    end
                endcase
            end

            // A finished tick loads the output beat; otherwise a taken beat clears it.
            if (state_reg == mrv_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (voice_out.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                mrv_pkg::ST_IDLE:
                begin
                    phase_reg <= '0;
                    mode_reg  <= '0;
                    if (in_beat)
                    begin
                        case (voice_in.cmd)
                            mrv_pkg::CMD_LOAD:
                            begin
                                if (32'(voice_in.mode_index) < mrv_pkg::MODE_COUNT)
                                begin
                                    coeff_reg[mrv_pkg::MODE_IDX_W'(voice_in.mode_index)]
                                        <= voice_in.feedback_coeff;
                                    radius_reg[mrv_pkg::MODE_IDX_W'(voice_in.mode_index)]
                                        <= voice_in.pole_radius_sq;
                                    gain_reg[mrv_pkg::MODE_IDX_W'(voice_in.mode_index)]
                                        <= voice_in.mode_gain;
                                end
                            end
                            mrv_pkg::CMD_NOTE_ON:
                            begin
                                for (int i = 0; i < mrv_pkg::MODE_COUNT; i++)
                                begin
                                    delay_one_reg[i] <= '0;
                                    delay_two_reg[i] <= '0;
                                end
                                strike_left_reg <= total;
                                noise_left_reg  <= (noise_gain_reg != 24'd0)
                                                   ? noise_samples_reg : 17'd0;
                                noise_level_reg <= noise_gain_reg;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                mrv_pkg::ST_EXC:
                begin
                    strike_left_reg <= strike_left_reg - 17'd1;
                end
                mrv_pkg::ST_MODE:
                begin
                    if (phase_reg == mrv_pkg::MODE_LAST_PH)
                    begin
                        delay_two_reg[mode_reg] <= s1;
                        delay_one_reg[mode_reg] <= y_new;
                        phase_reg <= '0;
                        if (mode_reg != mode_last)
                            mode_reg <= mode_reg + mrv_pkg::MODE_IDX_W'(1);
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 3'd1;
                    end
                end
                mrv_pkg::ST_NOISE:
                begin
                    phase_reg <= phase_reg + 3'd1;
                    if (phase_reg == 3'd0)
                        lcg_reg <= lcg_next;
                    if (phase_reg == mrv_pkg::NOISE_LAST_PH)
                    begin
                        noise_level_reg <= prod[47:24];
                        noise_left_reg  <= noise_left_reg - 17'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers with no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mrv_pkg::ST_IDLE:
            begin
                exc_reg <= '0;
                acc_reg <= '0;
            end
            mrv_pkg::ST_EXC:
            begin
                exc_reg <= mrv_pkg::COS_TABLE[div_quot];
            end
            mrv_pkg::ST_MODE:
            begin
                case (phase_reg)
                    3'd1:
                    begin
                        t_reg <= prod_ext;
                    end
                    3'd2:
                    begin
                        t_reg <= t_reg + (prod_ext <<< 20);
                    end
                    3'd3:
                    begin
                        // Feedback term is complete; start the damping term.
                        y_reg <= mrv_pkg::ACC_W'(t_reg >>> 22);
                        t_reg <= prod_ext;
                    end
                    3'd4:
                    begin
                        t_reg <= t_reg + (prod_ext <<< 20);
                    end
                    mrv_pkg::MODE_LAST_PH:
                    begin
                        acc_reg <= acc_reg + mrv_pkg::ACC_W'(y_new);
                    end
                    default:
                    begin
                    end
                endcase
            end
            mrv_pkg::ST_NOISE:
            begin
                case (phase_reg)
                    3'd2:
                    begin
                        t_reg <= prod_ext;
                    end
                    3'd3:
                    begin
                        t_reg <= t_reg + (prod_ext <<< 16);
                    end
                    mrv_pkg::NOISE_LAST_PH:
                    begin
                        acc_reg <= acc_reg + mrv_pkg::ACC_W'(t_reg >>> 30);
                    end
                    default:
                    begin
                    end
                endcase
            end
            mrv_pkg::ST_DONE:
            begin
                if (out_free)
                    out_data_reg <= mrv_pkg::sat40(acc_reg);
            end
            default:
            begin
            end
        endcase
    end

    // The mode walk never passes the clamped last slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mrv_pkg::ST_MODE |-> mode_reg <= mode_last)
        else $error("mode counter ran past the active slot range");

    // A fresh output beat only appears out of the done state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == mrv_pkg::ST_DONE)
        else $error("output beat raised outside the done state");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == mrv_pkg::ST_DIV)
        else $error("divider finished outside its wait state");

    // Entering the noise phase requires a running burst.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mrv_pkg::ST_NOISE |-> noise_left_reg != 17'd0)
        else $error("noise phase entered with an idle burst");

endmodule

@@ rtl/mrv_mul.sv @@
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module mrv_mul (
    input  logic                                clk,
    input  logic signed [mrv_pkg::MUL_W-1:0]    op_a,
    input  logic signed [mrv_pkg::MUL_W-1:0]    op_b,
    output logic signed [mrv_pkg::PROD_W-1:0]   prod
);

    logic signed [mrv_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/mrv_div.sv @@
`timescale 1ns / 1ps

// Restoring divider for the envelope table index: one quotient bit per cycle.
// The dividend is always below the divisor, so the quotient is a fraction
// scaled by the table depth.
module mrv_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [16:0]                       dividend,
    input  logic [16:0]                       divisor,
    output logic                              done,
    output logic [mrv_pkg::COS_IDX_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(mrv_pkg::COS_IDX_W + 1);

    logic                            busy_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [16:0]                     rem_reg;
    logic [mrv_pkg::COS_IDX_W-1:0]   quot_reg;
    logic                            done_reg;
    logic [17:0]                     shifted;
    logic                            fits;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(mrv_pkg::COS_IDX_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? 17'(shifted - {1'b0, divisor}) : shifted[16:0];
            quot_reg <= {quot_reg[mrv_pkg::COS_IDX_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
